// ===== rtl/pte_pkg.sv =====
// ----------------------------------------------------------------------------
// pte_pkg
// Types and constants shared by the header tuple extractor modules.
// ----------------------------------------------------------------------------
package pte_pkg;

  // Link type register codes
  localparam logic [2:0] LINK_ETHERNET = 3'd0;
  localparam logic [2:0] LINK_PPP      = 3'd1;
  localparam logic [2:0] LINK_COOKED   = 3'd2;
  localparam logic [2:0] LINK_RAW      = 3'd3;

  // Network protocol codes
  localparam logic [15:0] ETH_IPV4     = 16'h0800;
  localparam logic [15:0] ETH_IPV6     = 16'h86DD;
  localparam logic [15:0] PPP_PROTO_V4 = 16'h0021;
  localparam logic [15:0] PPP_PROTO_V6 = 16'h0057;

  // Transport protocol numbers
  localparam logic [7:0] PROTO_TCP = 8'd6;
  localparam logic [7:0] PROTO_UDP = 8'd17;

  typedef enum logic [1:0] {
    NET_NONE = 2'd0,
    NET_IPV4 = 2'd1,
    NET_IPV6 = 2'd2
  } net_kind_t;

  typedef enum logic [1:0] {
    TRN_NONE = 2'd0,
    TRN_TCP  = 2'd1,
    TRN_UDP  = 2'd2
  } trn_kind_t;

  typedef struct packed {
    logic [7:0]  data_byte;
    logic        last_byte;
    logic [15:0] wire_length;
  } in_item_t;

  typedef struct packed {
    logic        is_ipv6;
    logic        is_udp;
    logic [63:0] source_high;
    logic [63:0] source_low;
    logic [63:0] dest_high;
    logic [63:0] dest_low;
    logic [15:0] source_port;
    logic [15:0] dest_port;
    logic [15:0] frame_length;
  } out_item_t;

  // Byte after link classification, as queued for the back end
  typedef struct packed {
    logic [7:0]  data_byte;
    logic        last_byte;
    logic [15:0] wire_length;
    logic [7:0]  position;
    logic [2:0]  link_type;
    net_kind_t   net_kind;
  } tagged_t;

endpackage

// ===== rtl/pte_front.sv =====
// ----------------------------------------------------------------------------
// pte_front
// Accepts bytes, counts position and decodes the link header protocol.
// ----------------------------------------------------------------------------
module pte_front (
  input  logic             clk,
  input  logic             rst,
  input  logic [2:0]       link_type,
  input  logic             in_valid,
  output logic             in_ready,
  input  pte_pkg::in_item_t in_data,
  input  logic             q_full,
  output logic             push,
  output pte_pkg::tagged_t push_data
);
  import pte_pkg::*;

  logic [7:0]  byte_position;
  logic [7:0]  byte_position_next;
  logic [15:0] protocol_word;
  logic [15:0] protocol_word_next;
  net_kind_t   network_kind;
  net_kind_t   network_kind_next;

  logic [7:0]  hi_pos;
  logic [15:0] code_v4;
  logic [15:0] code_v6;
  logic        has_link_hdr;

  always_comb begin
    in_ready = !q_full;
    push     = in_valid && in_ready;

    has_link_hdr = 1'b1;
    hi_pos       = 8'd12;
    code_v4      = ETH_IPV4;
    code_v6      = ETH_IPV6;
    case (link_type)
      LINK_ETHERNET: begin
        hi_pos = 8'd12;
      end
      LINK_PPP: begin
        hi_pos  = 8'd2;
        code_v4 = PPP_PROTO_V4;
        code_v6 = PPP_PROTO_V6;
      end
      LINK_COOKED: begin
        hi_pos = 8'd14;
      end
      default: begin
        has_link_hdr = 1'b0;
      end
    endcase

    protocol_word_next = protocol_word;
    network_kind_next  = network_kind;
    if (link_type == LINK_RAW) begin
      // raw link: IPv4 assumed from the first byte
      if (byte_position == 8'd0) begin
        network_kind_next = NET_IPV4;
      end
    end else if (has_link_hdr) begin
      if (byte_position == hi_pos) begin
        protocol_word_next = {in_data.data_byte, 8'h00};
      end else if (byte_position == hi_pos + 8'd1) begin
        protocol_word_next = {protocol_word[15:8], in_data.data_byte};
        if (protocol_word_next == code_v4) begin
          network_kind_next = NET_IPV4;
        end else if (protocol_word_next == code_v6) begin
          network_kind_next = NET_IPV6;
        end else begin
          network_kind_next = NET_NONE;
        end
      end
    end

    byte_position_next = (byte_position == 8'hFF) ? byte_position : byte_position + 8'd1;

    push_data.data_byte   = in_data.data_byte;
    push_data.last_byte   = in_data.last_byte;
    push_data.wire_length = in_data.wire_length;
    push_data.position    = byte_position;
    push_data.link_type   = link_type;
    push_data.net_kind    = network_kind_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position <= '0;
      protocol_word <= '0;
      network_kind  <= NET_NONE;
    end else if (push) begin
      if (in_data.last_byte) begin
        byte_position <= '0;
        protocol_word <= '0;
        network_kind  <= NET_NONE;
      end else begin
        byte_position <= byte_position_next;
        protocol_word <= protocol_word_next;
        network_kind  <= network_kind_next;
      end
    end
  end

  a_frame_restart: assert property (@(posedge clk) disable iff (rst)
    push && in_data.last_byte |=> byte_position == 8'd0 && network_kind == NET_NONE)
    else $error("front state not cleared after last byte");

endmodule

// ===== rtl/pte_queue.sv =====
// ----------------------------------------------------------------------------
// pte_queue
// Small FIFO of classified bytes between front and back.
// ----------------------------------------------------------------------------
module pte_queue #(
  parameter int unsigned DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  pte_pkg::tagged_t push_data,
  output logic             full,
  input  logic             pop,
  output pte_pkg::tagged_t pop_data,
  output logic             empty
);
  import pte_pkg::*;

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_IDX = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

  tagged_t          mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign full     = (count == FULL_CNT);
  assign empty    = (count == '0);
  assign pop_data = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == LAST_IDX) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == LAST_IDX) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    !(push && full && !pop))
    else $error("queue overflow");

  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    !(pop && empty))
    else $error("queue underflow");

endmodule

// ===== rtl/pte_back.sv =====
// ----------------------------------------------------------------------------
// pte_back
// Loads network and transport fields and emits the tuple on the last byte.
// ----------------------------------------------------------------------------
module pte_back (
  input  logic               clk,
  input  logic               rst,
  input  logic               q_empty,
  input  pte_pkg::tagged_t   q_data,
  output logic               pop,
  output logic               out_valid,
  input  logic               out_ready,
  output pte_pkg::out_item_t out_data
);
  import pte_pkg::*;

  logic [6:0]  transport_start;
  logic [6:0]  transport_start_next;
  trn_kind_t   transport_kind;
  trn_kind_t   transport_kind_next;
  logic [63:0] src_hi;
  logic [63:0] src_hi_next;
  logic [63:0] src_lo;
  logic [63:0] src_lo_next;
  logic [63:0] dst_hi;
  logic [63:0] dst_hi_next;
  logic [63:0] dst_lo;
  logic [63:0] dst_lo_next;
  logic [31:0] port_pair;
  logic [31:0] port_pair_next;
  logic        ports_seen;
  logic        ports_seen_next;

  logic        link_ok;
  logic [4:0]  net_start;
  logic [7:0]  net_rel;
  logic [7:0]  trn_rel;
  logic [3:0]  ihl;
  logic [7:0]  b;
  trn_kind_t   code_kind;
  logic        emit;
  out_item_t   result;

  assign pop = !q_empty && (!out_valid || out_ready);

  always_comb begin
    b       = q_data.data_byte;
    link_ok = (q_data.link_type <= LINK_RAW);
    case (q_data.link_type)
      LINK_ETHERNET: net_start = 5'd14;
      LINK_PPP:      net_start = 5'd4;
      LINK_COOKED:   net_start = 5'd16;
      default:       net_start = 5'd0;
    endcase

    if (b == PROTO_TCP) begin
      code_kind = TRN_TCP;
    end else if (b == PROTO_UDP) begin
      code_kind = TRN_UDP;
    end else begin
      code_kind = TRN_NONE;
    end

    ihl = (q_data.data_byte[3:0] < 4'd5) ? 4'd5 : q_data.data_byte[3:0];

    transport_start_next = transport_start;
    transport_kind_next  = transport_kind;
    src_hi_next          = src_hi;
    src_lo_next          = src_lo;
    dst_hi_next          = dst_hi;
    dst_lo_next          = dst_lo;
    port_pair_next       = port_pair;
    ports_seen_next      = ports_seen;

    // network header
    net_rel = q_data.position - {3'b000, net_start};
    if (link_ok && q_data.net_kind != NET_NONE && q_data.position >= {3'b000, net_start}) begin
      if (q_data.net_kind == NET_IPV4) begin
        if (net_rel == 8'd0) begin
          transport_start_next = {2'b00, net_start} + {1'b0, ihl, 2'b00};
        end else if (net_rel == 8'd9) begin
          transport_kind_next = code_kind;
        end else if (net_rel >= 8'd12 && net_rel <= 8'd15) begin
          src_lo_next = {32'h0, src_lo[23:0], b};
        end else if (net_rel >= 8'd16 && net_rel <= 8'd19) begin
          dst_lo_next = {32'h0, dst_lo[23:0], b};
        end
      end else begin
        if (net_rel == 8'd0) begin
          transport_start_next = {2'b00, net_start} + 7'd40;
        end else if (net_rel == 8'd6) begin
          transport_kind_next = code_kind;
        end else if (net_rel >= 8'd8 && net_rel <= 8'd15) begin
          src_hi_next = {src_hi[55:0], b};
        end else if (net_rel >= 8'd16 && net_rel <= 8'd23) begin
          src_lo_next = {src_lo[55:0], b};
        end else if (net_rel >= 8'd24 && net_rel <= 8'd31) begin
          dst_hi_next = {dst_hi[55:0], b};
        end else if (net_rel >= 8'd32 && net_rel <= 8'd39) begin
          dst_lo_next = {dst_lo[55:0], b};
        end
      end
    end

    // transport header: four port bytes
    trn_rel = q_data.position - {1'b0, transport_start_next};
    if (link_ok && transport_kind_next != TRN_NONE && q_data.net_kind != NET_NONE &&
        transport_start_next != 7'd0 &&
        q_data.position >= {1'b0, transport_start_next} && trn_rel < 8'd4) begin
      port_pair_next = {port_pair[23:0], b};
      if (trn_rel == 8'd3) begin
        ports_seen_next = 1'b1;
      end
    end

    emit = q_data.last_byte && link_ok && ports_seen_next &&
           q_data.net_kind != NET_NONE && transport_kind_next != TRN_NONE;

    result.is_ipv6      = (q_data.net_kind == NET_IPV6);
    result.is_udp       = (transport_kind_next == TRN_UDP);
    result.source_high  = result.is_ipv6 ? src_hi_next : 64'h0;
    result.source_low   = result.is_ipv6 ? src_lo_next : {32'h0, src_lo_next[31:0]};
    result.dest_high    = result.is_ipv6 ? dst_hi_next : 64'h0;
    result.dest_low     = result.is_ipv6 ? dst_lo_next : {32'h0, dst_lo_next[31:0]};
    result.source_port  = port_pair_next[31:16];
    result.dest_port    = port_pair_next[15:0];
    result.frame_length = q_data.wire_length;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      transport_start <= '0;
      transport_kind  <= TRN_NONE;
      src_hi          <= '0;
      src_lo          <= '0;
      dst_hi          <= '0;
      dst_lo          <= '0;
      port_pair       <= '0;
      ports_seen      <= 1'b0;
      out_valid       <= 1'b0;
    end else begin
      if (pop) begin
        if (q_data.last_byte) begin
          transport_start <= '0;
          transport_kind  <= TRN_NONE;
          src_hi          <= '0;
          src_lo          <= '0;
          dst_hi          <= '0;
          dst_lo          <= '0;
          port_pair       <= '0;
          ports_seen      <= 1'b0;
        end else begin
          transport_start <= transport_start_next;
          transport_kind  <= transport_kind_next;
          src_hi          <= src_hi_next;
          src_lo          <= src_lo_next;
          dst_hi          <= dst_hi_next;
          dst_lo          <= dst_lo_next;
          port_pair       <= port_pair_next;
          ports_seen      <= ports_seen_next;
        end
      end
      if (pop && emit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop && emit) begin
      out_data <= result;
    end
  end

  a_result_from_last: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(pop && q_data.last_byte))
    else $error("result raised without a last byte");

  a_v4_high_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_data.is_ipv6 |-> out_data.source_high == 64'h0 &&
                                       out_data.dest_high == 64'h0)
    else $error("IPv4 result carries upper address bits");

endmodule

// ===== rtl/packet_header_tuple_extractor.sv =====
// ----------------------------------------------------------------------------
// packet_header_tuple_extractor: IP/TCP/UDP five-tuple header parser
// Path: the accepted last byte is written into the queue, then popped into the result register behind out_valid.
// Throughput: one byte per cycle; the front takes a byte each cycle the queue has room.
// Reset: link type returns to Ethernet; frame state, queue and out_valid clear (the result data is not reset).
// ----------------------------------------------------------------------------
module packet_header_tuple_extractor #(
  parameter int unsigned QUEUE_DEPTH = 2
) (
  input  logic               clk,
  input  logic               rst,
  // configuration: link type
  input  logic               cfg_wr_en,
  input  logic [2:0]         cfg_wr_data,
  // byte stream in
  input  logic               in_valid,
  output logic               in_ready,
  input  pte_pkg::in_item_t  in_data,
  // tuple out
  output logic               out_valid,
  input  logic               out_ready,
  output pte_pkg::out_item_t out_data
);
  import pte_pkg::*;

  // Link type register; the user must write it only between frames (not enforced here).
  logic [2:0] link_type;

  always_ff @(posedge clk) begin
    if (rst) begin
      link_type <= LINK_ETHERNET;
    end else if (cfg_wr_en) begin
      link_type <= cfg_wr_data;
    end
  end

  // Front -> queue -> back. The front counts bytes and resolves the link
  // header's protocol code, tagging each item with its position and the
  // network kind it implies. The back then loads addresses and ports.
  logic    push;
  tagged_t push_data;
  logic    q_full;
  logic    pop;
  tagged_t q_data;
  logic    q_empty;

  pte_front u_front (
    .clk       (clk),
    .rst       (rst),
    .link_type (link_type),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .q_full    (q_full),
    .push      (push),
    .push_data (push_data)
  );

  // Lets the front keep taking bytes, until the queue fills, while a result waits at the output.
  pte_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .full      (q_full),
    .pop       (pop),
    .pop_data  (q_data),
    .empty     (q_empty)
  );

  // The back pops whenever the queue holds a byte and the result register is free or being drained;
  // bytes that produce no result simply pass through it.
  pte_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_empty   (q_empty),
    .q_data    (q_data),
    .pop       (pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule
